>>> sv/cfpd_pkg.sv
// ---------------------------------------------------------------------------
// cfpd_pkg
// Types, constants and CRC byte-step functions for the framed packet deframer.
// ---------------------------------------------------------------------------
package cfpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned Crc16W  = 16;
  localparam int unsigned PosW    = 9;
  localparam int unsigned EventW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [ByteW-1:0]  StartMarkerRst   = 8'd170;
  localparam logic [ByteW-1:0]  HeaderCrcPolyRst = 8'd55;
  localparam logic [ByteW-1:0]  HeaderCrcInitRst = 8'd66;
  localparam logic [Crc16W-1:0] BodyCrcPolyRst   = 16'd15717;
  localparam logic [Crc16W-1:0] BodyCrcInitRst   = 16'd4919;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER    = 3'd0,
    CFG_HEADER_CRC_POLY = 3'd1,
    CFG_HEADER_CRC_INIT = 3'd2,
    CFG_BODY_CRC_POLY   = 3'd3,
    CFG_BODY_CRC_INIT   = 3'd4
  } cfg_idx_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE       = 3'd0,
    EV_MARKER     = 3'd1,
    EV_LENGTH     = 3'd2,
    EV_HEADER_OK  = 3'd3,
    EV_HEADER_BAD = 3'd4,
    EV_PACKET_OK  = 3'd5,
    EV_PACKET_BAD = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_HCRC = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]  start_marker;
    logic [ByteW-1:0]  header_crc_poly;
    logic [ByteW-1:0]  header_crc_init;
    logic [Crc16W-1:0] body_crc_poly;
    logic [Crc16W-1:0] body_crc_init;
  } cfg_t;

  // MSB-first, non-reflected CRC-8 over one byte
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b,
                                                 input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // MSB-first, non-reflected CRC-16 over one byte
  function automatic logic [Crc16W-1:0] crc16_byte(input logic [Crc16W-1:0] crc,
                                                   input logic [ByteW-1:0]  b,
                                                   input logic [Crc16W-1:0] poly);
    logic [Crc16W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[Crc16W-1]) begin
        c = {c[Crc16W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[Crc16W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/cfpd_cfg_regs.sv
// ---------------------------------------------------------------------------
// cfpd_cfg_regs
// Configuration register file; writes take effect on the next clock edge.
// ---------------------------------------------------------------------------
module cfpd_cfg_regs
  import cfpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= StartMarkerRst;
      cfg_q.header_crc_poly <= HeaderCrcPolyRst;
      cfg_q.header_crc_init <= HeaderCrcInitRst;
      cfg_q.body_crc_poly   <= BodyCrcPolyRst;
      cfg_q.body_crc_init   <= BodyCrcInitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_MARKER:    cfg_q.start_marker    <= cfg_wdata_i[ByteW-1:0];
        CFG_HEADER_CRC_POLY: cfg_q.header_crc_poly <= cfg_wdata_i[ByteW-1:0];
        CFG_HEADER_CRC_INIT: cfg_q.header_crc_init <= cfg_wdata_i[ByteW-1:0];
        CFG_BODY_CRC_POLY:   cfg_q.body_crc_poly   <= cfg_wdata_i[Crc16W-1:0];
        CFG_BODY_CRC_INIT:   cfg_q.body_crc_init   <= cfg_wdata_i[Crc16W-1:0];
        default: ;  // unused index: ignored
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/crc_framed_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// crc_framed_packet_deframer_core
// Length-prefixed frame parser with CRC-8 header and CRC-16 body checks.
// ---------------------------------------------------------------------------
// Result of an accepted input transaction is registered onto out_* next cycle.
// Throughput: one byte per cycle unless stalled; the byte-wide CRC-8/CRC-16
// update and the parser step are combinational ahead of the result register.
// Input is stalled only while a held result is stalled downstream.
// Reset (async, active low) returns to hunting, clears length and position,
// loads CRC registers with their defaults and empties the result register.
module crc_framed_packet_deframer_core
  import cfpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   in_data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   out_echo_byte_o,
  output logic               out_is_payload_o,
  output logic [PosW-1:0]    out_body_position_o,
  output logic [ByteW-1:0]   out_frame_length_o,
  output logic [EventW-1:0]  out_event_res_o
);

  cfg_t cfg;

  cfpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [PosW-1:0]   taken_q, taken_d;
  logic [Crc16W-1:0] crc_q, crc_d;

  logic              out_valid_q;
  logic [ByteW-1:0]  echo_q;
  logic              payload_q, payload_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]  flen_q;
  event_e            ev_q, ev_d;

  logic              in_accept;
  logic [ByteW-1:0]  hdr_crc;
  logic [PosW-1:0]   taken_inc;
  logic [PosW:0]     body_total;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign hdr_crc    = crc8_byte(crc8_byte(cfg.header_crc_init, cfg.start_marker,
                                          cfg.header_crc_poly),
                                len_q, cfg.header_crc_poly);
  assign taken_inc  = taken_q + PosW'(1);
  assign body_total = {2'b00, len_q} + (PosW+1)'(2);

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    taken_d   = taken_q;
    crc_d     = crc_q;
    payload_d = 1'b0;
    pos_d     = '0;
    ev_d      = EV_NONE;
    unique case (phase_q)
      PH_HUNT: begin
        if (in_data_byte_i == cfg.start_marker) begin
          phase_d = PH_LEN;
          ev_d    = EV_MARKER;
        end
      end
      PH_LEN: begin
        len_d   = in_data_byte_i;
        phase_d = PH_HCRC;
        ev_d    = EV_LENGTH;
      end
      PH_HCRC: begin
        if (hdr_crc == in_data_byte_i) begin
          phase_d = PH_BODY;
          taken_d = '0;
          crc_d   = cfg.body_crc_init;
          ev_d    = EV_HEADER_OK;
        end else begin
          phase_d = PH_HUNT;
          ev_d    = EV_HEADER_BAD;
        end
      end
      PH_BODY: begin
        pos_d     = taken_q;
        payload_d = (taken_q < {1'b0, len_q});
        crc_d     = crc16_byte(crc_q, in_data_byte_i, cfg.body_crc_poly);
        taken_d   = taken_inc;
        if ({1'b0, taken_inc} >= body_total) begin
          ev_d    = (crc_d == '0) ? EV_PACKET_OK : EV_PACKET_BAD;
          phase_d = PH_HUNT;
          taken_d = '0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      taken_q <= '0;
      crc_q   <= BodyCrcInitRst;
    end else if (in_accept) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      taken_q <= taken_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      echo_q    <= in_data_byte_i;
      payload_q <= payload_d;
      pos_q     <= pos_d;
      flen_q    <= len_d;
      ev_q      <= ev_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_echo_byte_o     = echo_q;
  assign out_is_payload_o    = payload_q;
  assign out_body_position_o = pos_q;
  assign out_frame_length_o  = flen_q;
  assign out_event_res_o     = ev_q;

endmodule

>>> sv/cfpd_checker.sv
// ---------------------------------------------------------------------------
// cfpd_checker
// Port-level assertions for the deframer, bound to the top level.
// ---------------------------------------------------------------------------
module cfpd_checker
  import cfpd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [ByteW-1:0]   in_data_byte_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ByteW-1:0]   out_echo_byte_o,
  input logic               out_is_payload_o,
  input logic [PosW-1:0]    out_body_position_o,
  input logic [ByteW-1:0]   out_frame_length_o,
  input logic [EventW-1:0]  out_event_res_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_echo_byte_o)
      && $stable(out_event_res_o) && $stable(out_body_position_o))
    else $error("result changed while stalled");

  // input is only stalled behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream stall");

  // an accepted byte shows up as a result on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o && out_echo_byte_o == $past(in_data_byte_i))
    else $error("accepted byte not echoed next cycle");

  // payload bytes sit inside the frame and carry no event
  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_is_payload_o |->
      out_event_res_o == EV_NONE && out_body_position_o < {1'b0, out_frame_length_o})
    else $error("payload flag inconsistent with position or event");

endmodule

bind crc_framed_packet_deframer_core cfpd_checker u_cfpd_checker (.*);

>>> tb/deframer_checker.sv
// ---------------------------------------------------------------------------
// deframer_checker
// Watches the config port and both byte channels of the deframer, predicts
// every output transaction from the bytes taken, and compares field by field.
// ---------------------------------------------------------------------------
package deframer_crc_pkg;

  // bit-serial MSB-first CRC-8 update
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = r << 1;
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  // bit-serial MSB-first CRC-16 update
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = r << 1;
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

module deframer_checker
  import cfpd_pkg::*;
  import deframer_crc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ByteW-1:0]   in_data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ByteW-1:0]   out_echo_byte_i,
  input  logic               out_is_payload_i,
  input  logic [PosW-1:0]    out_body_position_i,
  input  logic [ByteW-1:0]   out_frame_length_i,
  input  logic [EventW-1:0]  out_event_res_i,
  output int unsigned        pending_o,
  output int unsigned        fails_o
);

  typedef struct packed {
    logic [ByteW-1:0] echo;
    logic             payload;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] flen;
    event_e           ev;
  } parsed_byte_t;

  cfg_t              cfg;
  phase_e            phase;
  logic [ByteW-1:0]  body_len;
  logic [PosW-1:0]   taken;
  logic [Crc16W-1:0] body_crc;
  parsed_byte_t      parsed_q[$];

  function automatic parsed_byte_t parse_byte(input logic [ByteW-1:0] b);
    parsed_byte_t res;
    logic [ByteW-1:0] hcrc;
    res.echo    = b;
    res.payload = 1'b0;
    res.pos     = '0;
    res.ev      = EV_NONE;
    case (phase)
      PH_HUNT: begin
        if (b == cfg.start_marker) begin
          phase  = PH_LEN;
          res.ev = EV_MARKER;
        end
      end
      PH_LEN: begin
        body_len = b;
        phase    = PH_HCRC;
        res.ev   = EV_LENGTH;
      end
      PH_HCRC: begin
        hcrc = crc8_update(cfg.header_crc_init, cfg.start_marker, cfg.header_crc_poly);
        hcrc = crc8_update(hcrc, body_len, cfg.header_crc_poly);
        if (hcrc == b) begin
          phase    = PH_BODY;
          taken    = '0;
          body_crc = cfg.body_crc_init;
          res.ev   = EV_HEADER_OK;
        end else begin
          phase  = PH_HUNT;
          res.ev = EV_HEADER_BAD;
        end
      end
      default: begin
        res.pos     = taken;
        res.payload = (taken < {1'b0, body_len});
        body_crc    = crc16_update(body_crc, b, cfg.body_crc_poly);
        taken       = taken + 1'b1;
        if (taken >= {1'b0, body_len} + 9'd2) begin
          res.ev = (body_crc == '0) ? EV_PACKET_OK : EV_PACKET_BAD;
          phase  = PH_HUNT;
          taken  = '0;
        end
      end
    endcase
    res.flen = body_len;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fails_o++;
    if (fails_o <= 100) begin
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parsed_byte_t want;
    if (!rst_ni) begin
      cfg.start_marker    = StartMarkerRst;
      cfg.header_crc_poly = HeaderCrcPolyRst;
      cfg.header_crc_init = HeaderCrcInitRst;
      cfg.body_crc_poly   = BodyCrcPolyRst;
      cfg.body_crc_init   = BodyCrcInitRst;
      phase    = PH_HUNT;
      body_len = '0;
      taken    = '0;
      body_crc = BodyCrcInitRst;
      parsed_q.delete();
      fails_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_MARKER:    cfg.start_marker    = cfg_wdata_i[ByteW-1:0];
          CFG_HEADER_CRC_POLY: cfg.header_crc_poly = cfg_wdata_i[ByteW-1:0];
          CFG_HEADER_CRC_INIT: cfg.header_crc_init = cfg_wdata_i[ByteW-1:0];
          CFG_BODY_CRC_POLY:   cfg.body_crc_poly   = cfg_wdata_i;
          CFG_BODY_CRC_INIT:   cfg.body_crc_init   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        parsed_q.push_back(parse_byte(in_data_byte_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          report_mismatch("unexpected transaction, echo_byte", out_echo_byte_i, 0);
        end else begin
          want = parsed_q.pop_front();
          if (out_echo_byte_i !== want.echo) begin
            report_mismatch("echo_byte", out_echo_byte_i, want.echo);
          end
          if (out_is_payload_i !== want.payload) begin
            report_mismatch("is_payload", out_is_payload_i, want.payload);
          end
          if (out_body_position_i !== want.pos) begin
            report_mismatch("body_position", out_body_position_i, want.pos);
          end
          if (out_frame_length_i !== want.flen) begin
            report_mismatch("frame_length", out_frame_length_i, want.flen);
          end
          if (out_event_res_i !== want.ev) begin
            report_mismatch("event_res", out_event_res_i, want.ev);
          end
        end
      end
    end
    pending_o = parsed_q.size();
  end

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives the framed packet deframer with directed frames, then random streams
// of good, corrupted and noisy frames under several CRC settings and
// idle/stall patterns; the checker predicts and compares every byte.
// ---------------------------------------------------------------------------
module tb;
  import cfpd_pkg::*;
  import deframer_crc_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseBytes  = 40;
  localparam int unsigned NumPhases   = 6;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDatW-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ByteW-1:0]   in_data_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ByteW-1:0]   out_echo_byte_o;
  logic               out_is_payload_o;
  logic [PosW-1:0]    out_body_position_o;
  logic [ByteW-1:0]   out_frame_length_o;
  logic [EventW-1:0]  out_event_res_o;

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int unsigned pending_cnt;
  int unsigned fail_cnt;

  // config as last written, used to build frames
  logic [ByteW-1:0]  marker;
  logic [ByteW-1:0]  hdr_poly;
  logic [ByteW-1:0]  hdr_init;
  logic [Crc16W-1:0] body_poly;
  logic [Crc16W-1:0] body_init;
  logic [ByteW-1:0]  frame_body [256];

  crc_framed_packet_deframer_core i_dut (.*);

  deframer_checker i_chk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .in_data_byte_i      (in_data_byte_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_echo_byte_i     (out_echo_byte_o),
    .out_is_payload_i    (out_is_payload_o),
    .out_body_position_i (out_body_position_o),
    .out_frame_length_i  (out_frame_length_o),
    .out_event_res_i     (out_event_res_o),
    .pending_o           (pending_cnt),
    .fails_o             (fail_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // junk in the upper byte of 8-bit registers must be dropped
  task automatic write_settings(input logic [ByteW-1:0] m, input logic [ByteW-1:0] hp,
                                input logic [ByteW-1:0] hi, input logic [Crc16W-1:0] bp,
                                input logic [Crc16W-1:0] bi);
    marker    = m;
    hdr_poly  = hp;
    hdr_init  = hi;
    body_poly = bp;
    body_init = bi;
    write_reg(CFG_START_MARKER, {ByteW'($urandom), m});
    write_reg(CFG_HEADER_CRC_POLY, {ByteW'($urandom), hp});
    write_reg(CFG_HEADER_CRC_INIT, {ByteW'($urandom), hi});
    write_reg(CFG_BODY_CRC_POLY, bp);
    write_reg(CFG_BODY_CRC_INIT, bi);
    write_reg(CfgIdxW'($urandom_range(5, 7)), CfgDatW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned len, input bit bad_hdr, input bit bad_body);
    logic [ByteW-1:0]  hcrc;
    logic [Crc16W-1:0] bcrc;
    hcrc = crc8_update(crc8_update(hdr_init, marker, hdr_poly), ByteW'(len), hdr_poly);
    bcrc = body_init;
    if (bad_hdr) begin
      hcrc ^= ByteW'($urandom_range(1, 255));
    end
    send_byte(marker);
    send_byte(ByteW'(len));
    send_byte(hcrc);
    if (!bad_hdr) begin
      for (int i = 0; i < len; i++) begin
        bcrc = crc16_update(bcrc, frame_body[i], body_poly);
        send_byte(frame_body[i]);
      end
      if (bad_body) begin
        bcrc ^= Crc16W'($urandom_range(1, 65535));
      end
      send_byte(bcrc[15:8]);
      send_byte(bcrc[7:0]);
    end
  endtask

  function automatic logic [ByteW-1:0] noise_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      b = marker;
    end else if (b == marker) begin
      b = ~b;
    end
    return b;
  endfunction

  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned phase_end;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_START_MARKER;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_data_byte_i = '0;
    out_stall_i    = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    cycle_cnt      = 0;
    bytes_sent     = 0;
    marker         = StartMarkerRst;
    hdr_poly       = HeaderCrcPolyRst;
    hdr_init       = HeaderCrcInitRst;
    body_poly      = BodyCrcPolyRst;
    body_init      = BodyCrcInitRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(0, 1'b0, 1'b0);
    frame_body[0] = 8'hff;
    frame_body[1] = 8'h00;
    send_frame(2, 1'b0, 1'b1);
    send_frame(1, 1'b1, 1'b0);
    frame_body[0] = 8'h00;
    frame_body[1] = 8'hff;
    frame_body[2] = 8'h5a;
    send_frame(3, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: write_settings('0, '0, '0, '0, '0);
        2: write_settings('1, '1, '1, '1, '1);
        5: write_settings(StartMarkerRst, HeaderCrcPolyRst, HeaderCrcInitRst,
                          BodyCrcPolyRst, BodyCrcInitRst);
        default: write_settings(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                                Crc16W'($urandom), Crc16W'($urandom));
      endcase
      case (ph % 4)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 84;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 84;
        end
        default: begin
          in_idle_pct   = 7;
          out_stall_pct = 7;
        end
      endcase
      phase_end = bytes_sent + PhaseBytes;
      if (ph == 3) begin
        for (int i = 0; i < 255; i++) begin
          frame_body[i] = ByteW'($urandom);
        end
        send_frame(255, 1'b0, 1'b0);
      end
      while (bytes_sent < phase_end) begin
        repeat ($urandom_range(0, 2)) send_byte(noise_byte());
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 39) == 0) ? $urandom_range(8, 31) : $urandom_range(0, 7);
        for (int i = 0; i < len; i++) begin
          frame_body[i] = ByteW'($urandom);
        end
        send_frame(len, pick >= 80 && pick < 90, pick >= 90);
        if ($urandom_range(0, 29) == 0) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
